FILE: rtl/core/ncs_pkg.sv
package ncs_pkg;

  localparam int CH_W       = 8;
  localparam int IDX_W      = 8;
  localparam int DIST_W     = 18;
  localparam int FIELD_LANES = 3;
  localparam int ADDR_W_MAX = 12;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CODEVECTORS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS    = 1'd1;

  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0] chan0;
    logic [CH_W-1:0] chan1;
    logic [CH_W-1:0] chan2;
    logic            frame_end;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
    logic              frame_end_out;
  } out_t;

  // Travels down the cell chain next to each codeword beat.
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [ADDR_W_MAX-1:0] idx;
  } ncs_tag_t;

endpackage

FILE: rtl/core/ncs_ram.sv
module ncs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ncs_cell.sv
module ncs_cell
  import ncs_pkg::*;
#(
  parameter int SAMPLE_BITS = 8,
  parameter int LANES       = 3,
  parameter int SUM_W       = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pix_load,
  input  logic [SAMPLE_BITS-1:0]       pix_in,
  input  logic                         active,
  input  ncs_tag_t                     tag_in,
  input  logic [LANES*SAMPLE_BITS-1:0] cw_in,
  input  logic [SUM_W-1:0]             sum_in,
  output ncs_tag_t                     tag_out,
  output logic [LANES*SAMPLE_BITS-1:0] cw_out,
  output logic [SUM_W-1:0]             sum_out
);

  logic [SAMPLE_BITS-1:0]       pix_r;
  logic [SAMPLE_BITS-1:0]       cw_s;
  logic [SAMPLE_BITS-1:0]       diff;
  logic [2*SAMPLE_BITS-1:0]     sq;
  logic [SUM_W-1:0]             sum_nxt;
  logic [LANES*SAMPLE_BITS-1:0] cw_nxt;
  ncs_tag_t                     tag_r;
  logic [LANES*SAMPLE_BITS-1:0] cw_r;
  logic [SUM_W-1:0]             sum_r;

  // Each cell consumes the lowest lane and shifts the rest on to its neighbor.
  always_comb begin
    cw_s    = cw_in[SAMPLE_BITS-1:0];
    diff    = (pix_r > cw_s) ? (pix_r - cw_s) : (cw_s - pix_r);
    sq      = diff * diff;
    sum_nxt = sum_in + (active ? SUM_W'(sq) : SUM_W'(0));
    cw_nxt  = cw_in >> SAMPLE_BITS;
  end

  always_ff @(posedge clk) begin
    if (pix_load) begin
      pix_r <= pix_in;
    end
    cw_r  <= cw_nxt;
    sum_r <= sum_nxt;
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  assign tag_out = tag_r;
  assign cw_out  = cw_r;
  assign sum_out = sum_r;

endmodule

FILE: rtl/core/nearest_codevector_search.sv
// Nearest-codevector search for a vector quantizer. An input beat with opcode
// write stores chan0..chan2 into codebook entry entry_index (modulo the depth)
// and gives no result. A classify beat reads the first num_codevectors entries
// from the codebook RAM, one entry per cycle through its single read port, and
// streams them down a chain of one cell per channel that builds the squared
// distance; a tracker after the chain keeps the nearest entry, lowest index on
// ties. A classify beat keeps the block busy from acceptance while it reads the
// entries and while the last one passes the RAM read register, each cell of the
// chain and the result register; the block then returns to idle and can take
// the next beat. The result waits in an output register and a following write
// beat is accepted meanwhile. Codebook entries must be written before a
// classify beat searches them; the codebook is not cleared at reset.
module nearest_codevector_search
  import ncs_pkg::*;
#(
  parameter int CODEBOOK_DEPTH = 256,
  parameter int MAX_CHANNELS   = 3,
  parameter int SAMPLE_BITS    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NL     = (MAX_CHANNELS > FIELD_LANES) ? FIELD_LANES : MAX_CHANNELS;
  localparam int AW     = $clog2(CODEBOOK_DEPTH);
  localparam int CNT_W  = $clog2(CODEBOOK_DEPTH + 1);
  localparam int NW     = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
  localparam int SUM_W  = 2 * SAMPLE_BITS + 2;
  localparam int SAT_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;
  localparam int WORD_W = NL * SAMPLE_BITS;
  localparam int IDX_RANGE = 2 ** IDX_W;

  // Entry indexes wrap at the depth; each index value maps to a constant address.
  function automatic logic [AW-1:0] wrap_entry(logic [IDX_W-1:0] e);
    logic [AW-1:0] w;
    w = '0;
    for (int v = 0; v < IDX_RANGE; v++) begin
      if (e == IDX_W'(v)) begin
        w = AW'(v % CODEBOOK_DEPTH);
      end
    end
    return w;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  state_t                state_r;
  logic [CFG_DATA_W-1:0] num_codevectors_r;
  logic [1:0]            num_channels_r;
  logic [AW-1:0]         j_r;
  logic                  fe_r;
  logic [DIST_W-1:0]     best_d_r;
  logic [AW-1:0]         best_i_r;
  logic                  out_valid_r;
  out_t                  out_data_r;
  ncs_tag_t              tag_rd_r;

  logic                  in_fire;
  logic                  wr_fire;
  logic                  cls_fire;
  logic [NW-1:0]         ncv_ext;
  logic [AW-1:0]         last_idx;
  logic [1:0]            nch_eff;
  logic [WORD_W-1:0]     wr_word;
  logic [AW-1:0]         wr_addr;
  logic [WORD_W-1:0]     rd_word;
  logic [CH_W-1:0]       chan_arr [FIELD_LANES];
  logic                  issuing;

  ncs_tag_t              tag_chain [NL+1];
  logic [WORD_W-1:0]     cw_chain  [NL+1];
  logic [SUM_W-1:0]      sum_chain [NL+1];

  ncs_tag_t              tail;
  logic [SAT_W-1:0]      sum_ext;
  logic [DIST_W-1:0]     tail_d;
  logic                  take_tail;
  logic [DIST_W-1:0]     best_d_nxt;
  logic [AW-1:0]         best_i_nxt;

  assign in_ready = (state_r == ST_IDLE) &&
                    ((in_data.opcode == OP_WRITE) || !out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign wr_fire  = in_fire && (in_data.opcode == OP_WRITE);
  assign cls_fire = in_fire && (in_data.opcode == OP_CLASSIFY);
  assign issuing  = (state_r == ST_ISSUE);
  assign wr_addr  = wrap_entry(in_data.entry_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_codevectors_r <= CFG_DATA_W'(1);
      num_channels_r    <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_CODEVECTORS: num_codevectors_r <= cfg_wdata;
        CFG_NUM_CHANNELS:    num_channels_r    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Zero entries searches entry 0 alone; too many saturates at the depth.
  always_comb begin
    ncv_ext = NW'(num_codevectors_r);
    if (ncv_ext == '0) begin
      last_idx = '0;
    end else if (ncv_ext > NW'(CODEBOOK_DEPTH)) begin
      last_idx = AW'(CODEBOOK_DEPTH - 1);
    end else begin
      last_idx = AW'(ncv_ext - NW'(1));
    end
    nch_eff = (num_channels_r > 2'(NL)) ? 2'(NL) : num_channels_r;
  end

  always_comb begin
    chan_arr[0] = in_data.chan0;
    chan_arr[1] = in_data.chan1;
    chan_arr[2] = in_data.chan2;
    wr_word     = '0;
    for (int k = 0; k < NL; k++) begin
      wr_word[k*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(chan_arr[k]);
    end
  end

  ncs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CODEBOOK_DEPTH)
  ) u_codebook (
    .clk  (clk),
    .we   (wr_fire),
    .waddr(wr_addr),
    .wdata(wr_word),
    .re   (issuing),
    .raddr(j_r),
    .rdata(rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_rd_r <= '0;
    end else begin
      tag_rd_r.valid <= issuing;
      tag_rd_r.last  <= (j_r == last_idx);
      tag_rd_r.idx   <= ADDR_W_MAX'(j_r);
    end
  end

  assign tag_chain[0] = tag_rd_r;
  assign cw_chain[0]  = rd_word;
  assign sum_chain[0] = '0;

  for (genvar k = 0; k < NL; k++) begin : g_cell
    ncs_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .LANES      (NL),
      .SUM_W      (SUM_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .pix_load(cls_fire),
      .pix_in  (SAMPLE_BITS'(chan_arr[k])),
      .active  (nch_eff > 2'(k)),
      .tag_in  (tag_chain[k]),
      .cw_in   (cw_chain[k]),
      .sum_in  (sum_chain[k]),
      .tag_out (tag_chain[k+1]),
      .cw_out  (cw_chain[k+1]),
      .sum_out (sum_chain[k+1])
    );
  end

  // Only wide samples can push the sum past the distance field.
  always_comb begin
    tail      = tag_chain[NL];
    sum_ext   = SAT_W'(sum_chain[NL]);
    tail_d    = (sum_ext > SAT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum_ext);
    take_tail = (tail.idx == '0) || (tail_d < best_d_r);
    if (take_tail) begin
      best_d_nxt = tail_d;
      best_i_nxt = tail.idx[AW-1:0];
    end else begin
      best_d_nxt = best_d_r;
      best_i_nxt = best_i_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (tail.valid) begin
        best_d_r <= best_d_nxt;
        best_i_r <= best_i_nxt;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cls_fire) begin
            j_r     <= '0;
            fe_r    <= in_data.frame_end;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          j_r <= j_r + AW'(1);
          if (j_r == last_idx) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (tail.valid && tail.last) begin
            out_data_r.best_index    <= IDX_W'(best_i_nxt);
            out_data_r.best_distance <= best_d_nxt;
            out_data_r.frame_end_out <= fe_r;
            out_valid_r              <= 1'b1;
            state_r                  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/ncs_checker.sv
module ncs_checker
  import ncs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input in_t                   in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_t                  out_data,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // A waiting result beat holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  // A search never starts while its result would have nowhere to go.
  a_cls_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && (in_data.opcode == OP_CLASSIFY) && out_valid && !out_ready |-> !in_ready)
    else $error("classify beat accepted while the result register is full");

  // A classify beat keeps the block busy, so no beat is taken right after it.
  a_cls_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_CLASSIFY) |=> !in_ready)
    else $error("input taken right after a classify beat");

  // A codebook write on an idle block produces no result.
  a_wr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_WRITE) && !out_valid |=> !out_valid)
    else $error("result beat appeared after a codebook write");

  // Register writes carry a defined index and value.
  a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !$isunknown({cfg_index, cfg_wdata}))
    else $error("register write with unknown index or data");

endmodule

bind nearest_codevector_search ncs_checker u_ncs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data),
  .cfg_we   (cfg_we),
  .cfg_index(cfg_index),
  .cfg_wdata(cfg_wdata)
);

FILE: tb/nearest_codevector_search_test.sv
module nearest_codevector_search_test;
  import ncs_pkg::*;

  localparam int DEPTH = 256;
  localparam int SETTLE_CYCLES = 270;
  localparam int LONG_HOLD = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int RAND_PHASES = 14;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Copy of the codebook, updated as beats are accepted, and of the two registers.
  logic [CH_W-1:0] codebook_copy [0:DEPTH-1][0:FIELD_LANES-1];
  logic [8:0] ncv_copy = 9'd1;
  logic [1:0] nch_copy = 2'd1;

  out_t nearest_due [$];
  in_t pixel_queue [$];
  bit entry_loaded [DEPTH];

  int n_offered = 0;
  int n_taken = 0;
  int n_results = 0;
  int n_errors = 0;
  int tx_gap = 0;
  int tx_mode = 1;
  int rx_gap = 0;
  int rx_mode = 1;
  int quiet = 0;

  nearest_codevector_search DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_t search_nearest(in_t px);
    logic [CH_W-1:0] pix [0:2];
    int unsigned lanes;
    int unsigned entries;
    int unsigned d;
    int unsigned best_d;
    int unsigned diff;
    int unsigned best;
    out_t r;
    pix[0] = px.chan0;
    pix[1] = px.chan1;
    pix[2] = px.chan2;
    lanes = nch_copy;
    if (ncv_copy == 0) entries = 1;
    else if (ncv_copy > DEPTH) entries = DEPTH;
    else entries = ncv_copy;
    best = 0;
    best_d = 0;
    for (int j = 0; j < entries; j++) begin
      d = 0;
      for (int c = 0; c < lanes; c++) begin
        if (pix[c] > codebook_copy[j][c]) diff = pix[c] - codebook_copy[j][c];
        else diff = codebook_copy[j][c] - pix[c];
        d += diff * diff;
      end
      if (d > DIST_MAX) d = DIST_MAX;
      // Strict compare keeps the lowest index on a tie.
      if (j == 0 || d < best_d) begin
        best_d = d;
        best = j;
      end
    end
    r.best_index = best[IDX_W-1:0];
    r.best_distance = best_d[DIST_W-1:0];
    r.frame_end_out = px.frame_end;
    return r;
  endfunction

  task automatic take_beat(in_t b);
    if (b.opcode == OP_WRITE) begin
      codebook_copy[b.entry_index][0] = b.chan0;
      codebook_copy[b.entry_index][1] = b.chan1;
      codebook_copy[b.entry_index][2] = b.chan2;
    end else begin
      nearest_due.push_back(search_nearest(b));
    end
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (nearest_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, got index %0d distance %0d end %0b",
               $time, got.best_index, got.best_distance, got.frame_end_out);
      n_errors++;
    end else begin
      want = nearest_due.pop_front();
      if (got.best_index !== want.best_index) begin
        $display("%0t: best_index expected %0d, got %0d",
                 $time, want.best_index, got.best_index);
        n_errors++;
      end
      if (got.best_distance !== want.best_distance) begin
        $display("%0t: best_distance expected %0d, got %0d",
                 $time, want.best_distance, got.best_distance);
        n_errors++;
      end
      if (got.frame_end_out !== want.frame_end_out) begin
        $display("%0t: frame_end_out expected %0b, got %0b",
                 $time, want.frame_end_out, got.frame_end_out);
        n_errors++;
      end
    end
  endtask

  function automatic int idle_draw(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  // Driver: one beat at a time from the pixel queue, with a drawn gap after each.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        take_beat(in_data);
        n_taken++;
        if (n_taken % 32 == 0) tx_mode = $urandom_range(0, 2);
        tx_gap = idle_draw(tx_mode);
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          in_data <= pixel_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: now and then a long hold-off so the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        n_results++;
        if (n_results % 32 == 0) rx_mode = $urandom_range(0, 2);
        if (n_results % 250 == 60) rx_gap = LONG_HOLD;
        else rx_gap = idle_draw(rx_mode);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic in_t make_item(logic op, logic [7:0] idx, logic [7:0] c0, c1, c2,
                                    logic fe);
    in_t b;
    b.opcode = op;
    b.entry_index = idx;
    b.chan0 = c0;
    b.chan1 = c1;
    b.chan2 = c2;
    b.frame_end = fe;
    return b;
  endfunction

  function automatic logic [7:0] pick_sample();
    // A small palette makes ties and exact hits common.
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 3) * 85);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic offer(in_t b);
    pixel_queue.push_back(b);
    n_offered++;
    if (b.opcode == OP_WRITE) entry_loaded[b.entry_index] = 1'b1;
  endtask

  task automatic drain();
    while (n_taken != n_offered || nearest_due.size() != 0) @(posedge clk);
    // Write beats give no result, so let any still in flight land.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] ncv_word, logic [CFG_DATA_W-1:0] nch_word);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NUM_CODEVECTORS;
    cfg_wdata <= ncv_word;
    @(posedge clk);
    cfg_index <= CFG_NUM_CHANNELS;
    cfg_wdata <= nch_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    ncv_copy = ncv_word;
    nch_copy = nch_word[1:0];
  endtask

  initial begin
    int ncv_cfg;
    int entries;
    int items;
    logic [CFG_DATA_W-1:0] nch_word;
    logic [7:0] idx;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one codevector, one channel.
    offer(make_item(OP_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    offer(make_item(OP_CLASSIFY, 8'hFF, 8'd255, 8'd255, 8'd255, 1'b1));
    offer(make_item(OP_CLASSIFY, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    offer(make_item(OP_WRITE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    offer(make_item(OP_WRITE, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0));
    offer(make_item(OP_CLASSIFY, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    drain();

    // Count zero searches entry 0 only; a black pixel gets the largest distance.
    configure(9'd0, 9'd3);
    offer(make_item(OP_CLASSIFY, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    offer(make_item(OP_CLASSIFY, 8'd7, 8'd255, 8'd0, 8'd128, 1'b1));
    drain();

    // Zero channels, with the upper data bits set: every distance is zero.
    configure(9'd3, 9'h1FC);
    offer(make_item(OP_WRITE, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0));
    offer(make_item(OP_WRITE, 8'd2, 8'd0, 8'd0, 8'd0, 1'b0));
    offer(make_item(OP_CLASSIFY, 8'd3, 8'd12, 8'd200, 8'd7, 1'b1));
    drain();

    // Entries 1 and 2 are equal, so a black pixel must land on 1.
    configure(9'd3, 9'd3);
    offer(make_item(OP_CLASSIFY, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    offer(make_item(OP_CLASSIFY, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1));
    drain();

    // Two channels: the third one must not count.
    configure(9'd3, 9'd2);
    offer(make_item(OP_WRITE, 8'd2, 8'd10, 8'd20, 8'd99, 1'b0));
    offer(make_item(OP_CLASSIFY, 8'd0, 8'd10, 8'd20, 8'd0, 1'b1));
    offer(make_item(OP_CLASSIFY, 8'd0, 8'd128, 8'd128, 8'd128, 1'b0));

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 5) ncv_cfg = DEPTH;
      else if (p == 10) ncv_cfg = $urandom_range(DEPTH + 1, 511);
      else if (p == 12) ncv_cfg = 0;
      else ncv_cfg = $urandom_range(1, 16);
      items = (p == 5 || p == 10) ? 30 : 64;
      nch_word = CFG_DATA_W'($urandom_range(0, 127) * 4 + (p % 4));
      drain();
      configure(CFG_DATA_W'(ncv_cfg), nch_word);
      if (ncv_cfg == 0) entries = 1;
      else if (ncv_cfg > DEPTH) entries = DEPTH;
      else entries = ncv_cfg;
      // Load every searched entry before the first pixel of the phase.
      for (int e = 0; e < entries; e++) begin
        if (!entry_loaded[e])
          offer(make_item(OP_WRITE, 8'(e), pick_sample(), pick_sample(), pick_sample(),
                          1'($urandom_range(0, 1))));
      end
      for (int k = 0; k < items; k++) begin
        if ($urandom_range(0, 1)) begin
          offer(make_item(OP_CLASSIFY, 8'($urandom_range(0, 255)), pick_sample(),
                          pick_sample(), pick_sample(), $urandom_range(0, 3) == 0));
        end else begin
          if ($urandom_range(0, 1)) idx = 8'($urandom_range(0, entries - 1));
          else idx = 8'($urandom_range(0, 255));
          offer(make_item(OP_WRITE, idx, pick_sample(), pick_sample(), pick_sample(),
                          1'($urandom_range(0, 1))));
        end
      end
    end

    drain();
    if (n_errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
